// ----- rtl/ptq_pkg.sv -----
package ptq_pkg;

  // list geometry
  localparam int CAPACITY   = 16;
  localparam int TAG_WIDTH  = 16;
  localparam int PRIO_WIDTH = 8;
  localparam int OCC_WIDTH  = $clog2(CAPACITY + 1);

  // operation codes carried by the input word
  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_REMOVE   = 2'd1,
    OP_SCHEDULE = 2'd2,
    OP_CLEAR    = 2'd3
  } op_e_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e_t;

  // one slot of the sorted list
  typedef struct packed {
    logic                  valid;
    logic [PRIO_WIDTH-1:0] prio;
    logic [TAG_WIDTH-1:0]  tag;
  } entry_t;

  // operation broadcast to every cell; en only for a taken request that changes the list or clears it
  typedef struct packed {
    logic                  en;
    op_e_t                 op;
    logic [PRIO_WIDTH-1:0] prio;
    logic [TAG_WIDTH-1:0]  tag;
  } cmd_t;

endpackage

// ----- rtl/ptq_if.sv -----
// request channel
interface ptq_in_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      opcode;
  logic [ptq_pkg::PRIO_WIDTH-1:0]  priority_req;
  logic [ptq_pkg::TAG_WIDTH-1:0]   task_id;

  modport source (output valid, output opcode, output priority_req, output task_id,
                  input ready);
  modport sink (input valid, input opcode, input priority_req, input task_id,
                output ready);
endinterface

// result channel
interface ptq_out_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      status;
  logic [ptq_pkg::TAG_WIDTH-1:0]   out_task_id;
  logic [ptq_pkg::PRIO_WIDTH-1:0]  out_priority;
  logic [ptq_pkg::OCC_WIDTH-1:0]   occupancy;

  modport source (output valid, output status, output out_task_id,
                  output out_priority, output occupancy, input ready);
  modport sink (input valid, input status, input out_task_id,
                input out_priority, input occupancy, output ready);
endinterface

// ----- rtl/ptq_cell.sv -----
module ptq_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  ptq_pkg::cmd_t   cmd,
  input  ptq_pkg::entry_t left_entry,
  input  ptq_pkg::entry_t right_entry,
  input  logic            left_ge,
  input  logic            found_in,
  output ptq_pkg::entry_t entry,
  output logic            ge_out,
  output logic            found_out
);

  ptq_pkg::entry_t entry_r;
  ptq_pkg::entry_t entry_nxt;
  logic            match;

  // local compares against the broadcast word
  assign ge_out    = entry_r.valid && (entry_r.prio >= cmd.prio);
  assign match     = entry_r.valid && (entry_r.tag == cmd.tag);
  assign found_out = found_in | match;
  assign entry     = entry_r;

  // pick own slot, new task or a neighbor
  always_comb begin
    entry_nxt = entry_r;
    unique case (cmd.op)
      ptq_pkg::OP_INSERT: begin
        if (!ge_out) begin
          if (left_ge) begin
            entry_nxt.valid = 1'b1;
            entry_nxt.prio  = cmd.prio;
            entry_nxt.tag   = cmd.tag;
          end else begin
            entry_nxt = left_entry;
          end
        end
      end
      ptq_pkg::OP_REMOVE: begin
        // the matching slot and every slot behind it close the gap
        if (found_out) entry_nxt = right_entry;
      end
      ptq_pkg::OP_SCHEDULE: begin
        entry_nxt = right_entry;
      end
      ptq_pkg::OP_CLEAR: begin
        entry_nxt.valid = 1'b0;
      end
      default: entry_nxt = entry_r;
    endcase
  end

  // slot register, only the occupancy flag is reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.valid <= 1'b0;
    end else if (cmd.en) begin
      entry_r <= entry_nxt;
    end
  end

endmodule

// ----- rtl/ptq_cell_row.sv -----
module ptq_cell_row (
  input  logic            clk,
  input  logic            rst_n,
  input  ptq_pkg::cmd_t   cmd,
  output ptq_pkg::entry_t head,
  output logic            full,
  output logic            found
);

  ptq_pkg::entry_t entries [ptq_pkg::CAPACITY];
  logic            ge      [ptq_pkg::CAPACITY];
  logic            hit     [ptq_pkg::CAPACITY];

  // row of cells, slot 0 at the head
  for (genvar i = 0; i < ptq_pkg::CAPACITY; i++) begin : g_cell
    ptq_pkg::entry_t left_entry;
    ptq_pkg::entry_t right_entry;
    logic            left_ge;
    logic            found_in;

    if (i == 0) begin : g_first
      assign left_entry = '0;
      assign left_ge    = 1'b1;
      assign found_in   = 1'b0;
    end else begin : g_mid
      assign left_entry = entries[i-1];
      assign left_ge    = ge[i-1];
      assign found_in   = hit[i-1];
    end

    if (i == ptq_pkg::CAPACITY - 1) begin : g_last
      assign right_entry = '0;
    end else begin : g_inner
      assign right_entry = entries[i+1];
    end

    ptq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .left_ge     (left_ge),
      .found_in    (found_in),
      .entry       (entries[i]),
      .ge_out      (ge[i]),
      .found_out   (hit[i])
    );
  end

  assign head  = entries[0];
  assign full  = entries[ptq_pkg::CAPACITY-1].valid;
  assign found = hit[ptq_pkg::CAPACITY-1];

endmodule

// ----- rtl/priority_task_queue.sv -----
// priority_task_queue: bounded ready list kept sorted by descending priority,
// arrival order among equal priorities.
// in_ch carries one request word: opcode (insert, remove by tag, schedule,
// clear), priority_req and task_id. out_ch returns one result word per
// request: status, the popped task (schedule only, else zero) and the
// number of tasks held afterwards.
// The list lives in a row of cells, one slot each; every request is broadcast
// to all cells, which compare locally and shift toward their neighbors in the
// same cycle. The result is registered and valid in the cycle after the
// request is taken. Throughput: one request per cycle, limited by the single
// output register; in_ch.ready is high whenever the output register is empty
// or is being taken in that cycle.
// When the receiver stalls, the result holds and further requests are
// refused until out_ch.ready returns.
// Reset (synchronous, rst_n low) empties the list and drops any pending
// result; no clearing pass is needed.
module priority_task_queue (
  input logic             clk,
  input logic             rst_n,
  ptq_in_if.sink          in_ch,
  ptq_out_if.source       out_ch
);

  ptq_pkg::cmd_t                   cmd;
  ptq_pkg::entry_t                 head;
  logic                            full;
  logic                            found;
  logic                            in_acc;
  ptq_pkg::op_e_t                  op;

  logic [ptq_pkg::OCC_WIDTH-1:0]   count_r;
  logic [ptq_pkg::OCC_WIDTH-1:0]   count_nxt;
  ptq_pkg::status_e_t              status_nxt;
  logic                            change;
  logic                            out_valid_r;
  ptq_pkg::status_e_t              status_r;
  logic [ptq_pkg::TAG_WIDTH-1:0]   otag_r;
  logic [ptq_pkg::TAG_WIDTH-1:0]   otag_nxt;
  logic [ptq_pkg::PRIO_WIDTH-1:0]  oprio_r;
  logic [ptq_pkg::PRIO_WIDTH-1:0]  oprio_nxt;

  // handshake
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign op          = ptq_pkg::op_e_t'(in_ch.opcode);

  // status, count and popped task for the current request
  always_comb begin
    status_nxt = ptq_pkg::ST_DONE;
    count_nxt  = count_r;
    change     = 1'b0;
    otag_nxt   = '0;
    oprio_nxt  = '0;
    unique case (op)
      ptq_pkg::OP_INSERT: begin
        if (full) begin
          status_nxt = ptq_pkg::ST_FULL;
        end else begin
          change    = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      ptq_pkg::OP_REMOVE: begin
        if (found) begin
          change    = 1'b1;
          count_nxt = count_r - 1'b1;
        end else begin
          status_nxt = ptq_pkg::ST_NOT_FOUND;
        end
      end
      ptq_pkg::OP_SCHEDULE: begin
        if (head.valid) begin
          change    = 1'b1;
          count_nxt = count_r - 1'b1;
          otag_nxt  = head.tag;
          oprio_nxt = head.prio;
        end else begin
          status_nxt = ptq_pkg::ST_EMPTY;
        end
      end
      ptq_pkg::OP_CLEAR: begin
        change    = 1'b1;
        count_nxt = '0;
      end
      default: status_nxt = ptq_pkg::ST_DONE;
    endcase
  end

  // broadcast word to the cell row
  assign cmd.en   = in_acc && change;
  assign cmd.op   = op;
  assign cmd.prio = in_ch.priority_req;
  assign cmd.tag  = in_ch.task_id;

  ptq_cell_row u_row (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .head  (head),
    .full  (full),
    .found (found)
  );

  // control: occupancy count and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) count_r <= count_nxt;
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (in_acc) begin
      status_r <= status_nxt;
      otag_r   <= otag_nxt;
      oprio_r  <= oprio_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = status_r;
  assign out_ch.out_task_id  = otag_r;
  assign out_ch.out_priority = oprio_r;
  assign out_ch.occupancy    = count_r;

  // count agrees with the cell row
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) == !head.valid)
    else $error("count and head slot disagree");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    full == (count_r == ptq_pkg::OCC_WIDTH'(ptq_pkg::CAPACITY)))
    else $error("count and last slot disagree");

  // a pop returns the head that was there
  a_pop_head: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && op == ptq_pkg::OP_SCHEDULE && head.valid) |=>
      (out_valid_r && status_r == ptq_pkg::ST_DONE && otag_r == $past(head.tag)))
    else $error("schedule result is not the old head");

  // clear empties the row
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && op == ptq_pkg::OP_CLEAR) |=> (!head.valid && count_r == '0))
    else $error("clear left tasks behind");

endmodule
